// File: hw/rtl/fwbp_pkg.sv
package fwbp_pkg;

   localparam int VALUE_W = 40;   // UQ32.8 input value
   localparam int CFG_W   = 6;    // code width register
   localparam int BYTE_W  = 8;
   localparam int HELD_W  = 3;    // pending bit count, 0..7
   localparam int CNT_W   = 3;    // bytes per request, 0..5

   localparam int DEF_MAX_CODE_WIDTH = 32;
   localparam int DEF_FRACTION_BITS  = 8;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [CFG_W-1:0] CODE_WIDTH_RESET = CFG_W'(12);

   typedef struct packed {
      logic [CNT_W-1:0] byte_count;   // bytes to emit for this request
      logic             fin;          // request closed the stream
   } fwbp_ctl_type;

endpackage

// File: hw/rtl/fwbp_ifs.sv
interface fwbp_req_if;
   logic                         valid;
   logic                         ready;
   logic [fwbp_pkg::VALUE_W-1:0] scaled_value;
   logic                         final_item;

   modport source (output valid, scaled_value, final_item, input ready);
   modport sink   (input valid, scaled_value, final_item, output ready);
endinterface

interface fwbp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fwbp_pkg::BYTE_W-1:0] packed_byte;
   logic                        run_last;
   logic                        stream_last;

   modport source (output valid, packed_byte, run_last, stream_last, input ready);
   modport sink   (input valid, packed_byte, run_last, stream_last, output ready);
endinterface

interface fwbp_csr_if;
   logic                       valid;
   logic                       ready;
   logic [fwbp_pkg::CFG_W-1:0] bits_per_value;

   modport source (output valid, bits_per_value, input ready);
   modport sink   (input valid, bits_per_value, output ready);
endinterface

// File: hw/rtl/fixed_width_bit_packer.sv
// Channel | Role | Handshake   | Payload
// --------+------+-------------+-----------------------------------------
// csr     | in   | valid/ready | bits_per_value (code width N, 0..63, saturates at 32)
// req     | in   | valid/ready | scaled_value (UQ32.8), final_item
// rsp     | out  | valid/ready | packed_byte, run_last, stream_last
//
// A request passes from the front register through the queue to the back
// shift register, from which its bytes leave one per cycle while rsp.ready
// is high. A request yields up to (7 + N)/8 + 1 bytes (pending bits, code,
// flush). Sustained throughput is set by the output byte rate on rsp.
// Reset (synchronous) empties the pipeline, clears the pending byte and sets
// N to 12. A stalled rsp backs up through a two-entry queue into req.ready.
module fixed_width_bit_packer #(
   parameter int MAX_CODE_WIDTH = fwbp_pkg::DEF_MAX_CODE_WIDTH,
   parameter int FRACTION_BITS  = fwbp_pkg::DEF_FRACTION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   fwbp_csr_if.sink    csr,
   fwbp_req_if.sink    req,
   fwbp_rsp_if.source  rsp
);
   import fwbp_pkg::*;

   localparam int WORD_W    = MAX_CODE_WIDTH + BYTE_W;
   localparam int CTL_W     = $bits(fwbp_ctl_type);
   localparam int JOB_W     = WORD_W + CTL_W;
   localparam int MAX_BYTES = (MAX_CODE_WIDTH + 7) / 8 + 1;

   // front -> queue
   logic              job_valid;
   logic              job_ready;
   logic [WORD_W-1:0] job_word;
   fwbp_ctl_type      job_ctl;

   // queue -> back
   logic              q_valid;
   logic              q_ready;
   logic [JOB_W-1:0]  q_data;
   logic [WORD_W-1:0] q_word;
   fwbp_ctl_type      q_ctl;

   // Front: config register, rounding, bit merge with the pending byte.
   fwbp_front #(
      .MAX_CODE_WIDTH (MAX_CODE_WIDTH),
      .FRACTION_BITS  (FRACTION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .req       (req),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_word  (job_word),
      .job_ctl   (job_ctl)
   );

   // Jobs are MSB-aligned words plus a byte count and fin flag; zero-byte requests never get here.
   fwbp_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (job_valid),
      .in_ready  (job_ready),
      .in_data   ({job_word, job_ctl}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   assign q_word = q_data[JOB_W-1 -: WORD_W];
   assign q_ctl  = fwbp_ctl_type'(q_data[CTL_W-1:0]);

   // Back: drains one byte per cycle while rsp.ready is high, flags the last byte of each request.
   fwbp_back #(
      .MAX_CODE_WIDTH (MAX_CODE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_ready (q_ready),
      .job_word  (q_word),
      .job_ctl   (q_ctl),
      .rsp       (rsp)
   );

   // end of stream is always the end of a request
   a_stream_last_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.stream_last |-> rsp.run_last)
      else $error("stream_last without run_last");

   // a queued job carries between one and the maximum number of bytes
   a_job_count: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (job_ctl.byte_count != '0)
                 && (job_ctl.byte_count <= CNT_W'(MAX_BYTES)))
      else $error("job byte count out of range");

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("rsp valid after reset");

endmodule

// File: hw/rtl/fwbp_front.sv
module fwbp_front #(
   parameter int MAX_CODE_WIDTH = fwbp_pkg::DEF_MAX_CODE_WIDTH,
   parameter int FRACTION_BITS  = fwbp_pkg::DEF_FRACTION_BITS,
   localparam int WORD_W        = MAX_CODE_WIDTH + fwbp_pkg::BYTE_W
) (
   input  logic                   clock,
   input  logic                   reset,
   fwbp_csr_if.sink               csr,
   fwbp_req_if.sink               req,
   output logic                   job_valid,
   input  logic                   job_ready,
   output logic [WORD_W-1:0]      job_word,
   output fwbp_pkg::fwbp_ctl_type job_ctl
);
   import fwbp_pkg::*;

   localparam logic [CFG_W-1:0]   MAX_N = CFG_W'(MAX_CODE_WIDTH);
   localparam logic [VALUE_W:0]   HALF  = (VALUE_W + 1)'(1) << (FRACTION_BITS - 1);

   logic [CFG_W-1:0]          bpv_ff, bpv_in;
   logic                      valid_ff, valid_in;
   logic [MAX_CODE_WIDTH-1:0] code_ff, code_in;
   logic [CFG_W-1:0]          n_ff, n_in;
   logic                      fin_ff, fin_in;
   logic [BYTE_W-1:0]         pend_ff, pend_in;
   logic [HELD_W-1:0]         held_ff, held_in;

   logic [CFG_W-1:0]          n_sat;
   logic [VALUE_W:0]          rounded;
   logic [MAX_CODE_WIDTH-1:0] code_left;
   logic [WORD_W-1:0]         word;
   logic [WORD_W-1:0]         shifted;
   logic [CFG_W-1:0]          total;
   logic [CNT_W-1:0]          full_cnt;
   logic                      flush;
   logic [CNT_W-1:0]          byte_count;
   logic                      done;

   assign csr.ready = 1'b1;

   // round half up, drop fraction, keep low n bits
   always_comb begin
      n_sat   = (bpv_ff > MAX_N) ? MAX_N : bpv_ff;
      rounded = ({1'b0, req.scaled_value} + HALF) >> FRACTION_BITS;
      code_in = rounded[MAX_CODE_WIDTH-1:0] & ~({MAX_CODE_WIDTH{1'b1}} << n_sat);
      n_in    = n_sat;
      fin_in  = req.final_item;
   end

   // merge code behind the pending bits, MSB aligned
   always_comb begin
      code_left  = code_ff << (MAX_N - n_ff);
      word       = {pend_ff, {MAX_CODE_WIDTH{1'b0}}}
                 | ({code_left, {BYTE_W{1'b0}}} >> held_ff);
      total      = CFG_W'(held_ff) + n_ff;
      full_cnt   = CNT_W'(total[CFG_W-1:3]);
      flush      = fin_ff && (total[2:0] != 3'd0);
      byte_count = full_cnt + CNT_W'(flush);
      shifted    = word << {full_cnt, 3'b000};
   end

   assign job_valid          = valid_ff && (byte_count != '0);
   assign job_word           = word;
   assign job_ctl.byte_count = byte_count;
   assign job_ctl.fin        = fin_ff;

   assign done      = valid_ff && ((byte_count == '0) || job_ready);
   assign req.ready = !valid_ff || done;

   always_comb begin
      bpv_in   = (csr.valid && csr.ready) ? csr.bits_per_value : bpv_ff;
      valid_in = valid_ff;
      pend_in  = pend_ff;
      held_in  = held_ff;
      if (done) begin
         valid_in = 1'b0;
         pend_in  = fin_ff ? '0 : shifted[WORD_W-1 -: BYTE_W];
         held_in  = fin_ff ? '0 : total[2:0];
      end
      if (req.valid && req.ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpv_ff   <= CODE_WIDTH_RESET;
         valid_ff <= 1'b0;
         pend_ff  <= '0;
         held_ff  <= '0;
      end else begin
         bpv_ff   <= bpv_in;
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         code_ff <= code_in;
         n_ff    <= n_in;
         fin_ff  <= fin_in;
      end
   end

endmodule

// File: hw/rtl/fwbp_queue.sv
module fwbp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != FULL_CNT;
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: hw/rtl/fwbp_back.sv
module fwbp_back #(
   parameter int MAX_CODE_WIDTH = fwbp_pkg::DEF_MAX_CODE_WIDTH,
   localparam int WORD_W        = MAX_CODE_WIDTH + fwbp_pkg::BYTE_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  logic [WORD_W-1:0]      job_word,
   input  fwbp_pkg::fwbp_ctl_type job_ctl,
   fwbp_rsp_if.source             rsp
);
   import fwbp_pkg::*;

   logic [WORD_W-1:0] word_ff, word_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic              fin_ff, fin_in;
   logic              last;
   logic              fire;
   logic              load;

   assign last      = left_ff == CNT_W'(1);
   assign fire      = rsp.valid && rsp.ready;
   // next job loads as the last byte of the current one leaves
   assign job_ready = (left_ff == '0) || (last && rsp.ready);
   assign load      = job_valid && job_ready;

   assign rsp.valid       = left_ff != '0;
   assign rsp.packed_byte = word_ff[WORD_W-1 -: BYTE_W];
   assign rsp.run_last    = last;
   assign rsp.stream_last = last && fin_ff;

   always_comb begin
      word_in = word_ff;
      left_in = left_ff;
      fin_in  = fin_ff;
      if (load) begin
         word_in = job_word;
         left_in = job_ctl.byte_count;
         fin_in  = job_ctl.fin;
      end else if (fire) begin
         word_in = word_ff << BYTE_W;
         left_in = left_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      fin_ff  <= fin_in;
   end

endmodule

// File: verif/packed_byte_checker.sv
module packed_byte_checker (
   input  logic   clock,
   input  logic   reset,
   fwbp_csr_if    csr,
   fwbp_req_if    req,
   fwbp_rsp_if    rsp,
   output int     mismatch_count,
   output int     pending_bytes,
   output int     bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import fwbp_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              run_last;
      logic              stream_last;
   } stream_byte_type;

   logic [CFG_W-1:0] width_cfg;
   logic [6:0]       held_bits;   // pending bits, right-aligned
   logic [3:0]       free_bits;   // free slots in the pending byte, 1..8
   stream_byte_type  expected_bytes[$];
   int               errors;
   int               checked;

   // Appends the bytes one request produces to the expected stream.
   task automatic pack_request(input logic [VALUE_W-1:0] value, input logic fin);
      int unsigned     n;
      int unsigned     total;
      logic [63:0]     acc;
      logic [63:0]     code;
      stream_byte_type burst[$];
      stream_byte_type one;
      n     = (width_cfg > DEF_MAX_CODE_WIDTH) ? DEF_MAX_CODE_WIDTH : width_cfg;
      total = 8 - free_bits;
      acc   = 64'(held_bits) & ((64'd1 << total) - 64'd1);
      if (n > 0) begin
         // round half up; a carry out of the integer part drops with the high bits
         code  = (64'(value) + (64'd1 << (DEF_FRACTION_BITS - 1))) >> DEF_FRACTION_BITS;
         code &= (64'd1 << n) - 64'd1;
         acc   = (acc << n) | code;
         total += n;
      end
      while (total >= 8) begin
         total -= 8;
         one.data        = 8'(acc >> total);
         one.run_last    = 1'b0;
         one.stream_last = 1'b0;
         burst.push_back(one);
      end
      acc &= (64'd1 << total) - 64'd1;
      if (fin) begin
         if (total > 0) begin
            one.data        = 8'(acc << (8 - total));
            one.run_last    = 1'b0;
            one.stream_last = 1'b0;
            burst.push_back(one);
         end
         held_bits = '0;
         free_bits = 4'd8;
      end else begin
         held_bits = 7'(acc);
         free_bits = 4'(8 - total);
      end
      if (burst.size() > 0) begin
         burst[burst.size()-1].run_last    = 1'b1;
         burst[burst.size()-1].stream_last = fin;
      end
      foreach (burst[i]) expected_bytes.push_back(burst[i]);
   endtask

   task automatic compare_byte();
      stream_byte_type want;
      if (expected_bytes.size() == 0) begin
         $error("packed_byte %02h arrived with nothing expected", rsp.packed_byte);
         errors++;
      end else begin
         want = expected_bytes.pop_front();
         checked++;
         if (rsp.packed_byte !== want.data) begin
            $error("packed_byte: expected %02h, got %02h", want.data, rsp.packed_byte);
            errors++;
         end
         if (rsp.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, rsp.run_last);
            errors++;
         end
         if (rsp.stream_last !== want.stream_last) begin
            $error("stream_last: expected %0b, got %0b", want.stream_last, rsp.stream_last);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_cfg = CODE_WIDTH_RESET;
         held_bits = '0;
         free_bits = 4'd8;
         expected_bytes.delete();
      end else begin
         if (rsp.valid && rsp.ready) compare_byte();
         if (csr.valid && csr.ready) width_cfg = csr.bits_per_value;
         if (req.valid && req.ready) pack_request(req.scaled_value, req.final_item);
      end
      mismatch_count <= errors;
      bytes_checked  <= checked;
      pending_bytes  <= expected_bytes.size();
   end

endmodule

// File: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fwbp_pkg::*;

   localparam int RANDOM_VALUES = 195;
   localparam int SETTLE_CYCLES = 10;      // front register + up to five bytes, with margin
   localparam int LONG_HOLD     = 80;      // receiver stall long enough to back up req
   localparam int HOLD_RUN      = 12;      // full-width requests offered during the stall
   localparam int DRAIN_LIMIT   = 5000;
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum int {GAP_NONE, GAP_LIGHT, GAP_FULL} gap_mode_type;

   logic clock;
   logic reset;

   fwbp_csr_if csr_if ();
   fwbp_req_if req_if ();
   fwbp_rsp_if rsp_if ();

   int mismatch_count;
   int pending_bytes;
   int bytes_checked;
   int cycle_count = 0;

   // shared between the request driver and the byte drain
   gap_mode_type req_mode = GAP_LIGHT;
   gap_mode_type rsp_mode = GAP_LIGHT;
   bit           long_hold_go = 1'b0;

   int value_count = 0;   // every request accepted
   int phase_count = 0;   // width settings used

   fixed_width_bit_packer uut (
      .clock (clock),
      .reset (reset),
      .csr   (csr_if),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   packed_byte_checker byte_check (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr_if),
      .req            (req_if),
      .rsp            (rsp_if),
      .mismatch_count (mismatch_count),
      .pending_bytes  (pending_bytes),
      .bytes_checked  (bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // hard stop: far beyond the slowest legal run (5 bytes/request, longest random ready gaps)
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int draw_gap(input gap_mode_type mode);
      case (mode)
         GAP_NONE:  return 0;
         GAP_LIGHT: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 19)) : 0;
         default:   return $urandom_range(0, 19);
      endcase
   endfunction

   // Byte drain: random ready gaps per byte, plus one long hold on request
   // from the stimulus so the internal queue fills and req.ready drops.
   initial begin : byte_drain
      int gap;
      int held;
      rsp_if.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold_go) begin
            long_hold_go = 1'b0;
            rsp_if.ready <= 1'b0;
            held = 0;
            while (held < LONG_HOLD) begin
               @(posedge clock);
               held++;
            end
         end
         gap = draw_gap(rsp_mode);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // Leaves valid high on return; anything that lets time pass afterwards
   // must drop it first (see wait_for_idle).
   task automatic send_value(input logic [VALUE_W-1:0] value, input logic fin);
      int gap;
      gap = draw_gap(req_mode);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.scaled_value <= value;
      req_if.final_item   <= fin;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      value_count++;
   endtask

   // Sender pause: all expected bytes out, then room for a request that
   // produced nothing to clear the pipeline.
   task automatic wait_for_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_bytes != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_width(input logic [CFG_W-1:0] width);
      wait_for_idle();
      csr_if.valid          <= 1'b1;
      csr_if.bits_per_value <= width;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      phase_count++;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      v = {8'($urandom), 32'($urandom)};
      case ($urandom_range(0, 7))
         0:       v = '1;
         1:       v[7:0] = 8'h80;      // exact half, rounds up
         2:       v[7:0] = 8'h7F;      // just below half
         3:       v = v >> $urandom_range(0, 39);
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [CFG_W-1:0] pick_width();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return CFG_W'(DEF_MAX_CODE_WIDTH);
         2:       return CFG_W'($urandom_range(33, 63));   // saturates to max
         default: return CFG_W'($urandom_range(1, 31));
      endcase
   endfunction

   initial begin : stimulus
      logic [CFG_W-1:0] width;
      int counted;
      int streams;
      int len;
      int waited;
      bit fin;
      bit hold_phase;

      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.scaled_value   = '0;
      req_if.final_item     = 1'b0;
      csr_if.valid          = 1'b0;
      csr_if.bits_per_value = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed ----
      // reset width of 12: zero, all ones (rounding carry wraps), half and
      // just-below-half rounding, then a final that flushes a partial byte
      phase_count = 1;
      send_value(40'h00_0000_0000, 1'b0);
      send_value(40'hFF_FFFF_FFFF, 1'b0);
      send_value(40'h00_0000_0080, 1'b0);
      send_value(40'h00_0000_007F, 1'b0);
      send_value(40'h12_3456_789A, 1'b1);

      // full width from an empty pending byte: four bytes per request, no flush byte
      set_width(CFG_W'(32));
      send_value(40'hFF_FFFF_FF7F, 1'b0);
      send_value(40'hFF_FFFF_FFFF, 1'b0);
      send_value(40'hAA_AAAA_AA80, 1'b1);

      // width dropped to zero mid-stream: nothing emitted until the final
      // flushes the bits left pending at width 3
      set_width(CFG_W'(3));
      send_value(40'h00_0000_05A5, 1'b0);
      set_width('0);
      send_value(40'h00_0000_FFFF, 1'b0);
      send_value(40'h00_0000_0000, 1'b1);
      // final with nothing pending and no code bits: no bytes at all
      send_value(40'hFF_FFFF_FFFF, 1'b1);

      // above-max widths saturate to 32
      set_width(CFG_W'(63));
      send_value(40'h55_5555_5555, 1'b0);
      send_value(40'h00_0000_00FF, 1'b1);
      set_width(CFG_W'(33));
      send_value(40'h33_3333_3380, 1'b1);

      // byte-aligned: final with nothing pending, stream_last on a full byte
      set_width(CFG_W'(8));
      send_value(40'h00_0000_1280, 1'b0);
      send_value(40'h00_0000_FF80, 1'b1);

      set_width(CFG_W'(1));
      send_value(40'h00_0000_0080, 1'b0);
      send_value(40'h00_0000_0000, 1'b0);
      send_value(40'h00_0000_0080, 1'b1);

      set_width(CFG_W'(7));
      send_value(40'h00_0000_7F80, 1'b1);

      // ---- random ----
      // Phases of a few streams each at one width; a phase may end
      // mid-stream so the next width picks up pending bits.
      counted = 0;
      while (counted < RANDOM_VALUES) begin
         hold_phase = (counted == 0);
         width = hold_phase ? CFG_W'(DEF_MAX_CODE_WIDTH) : pick_width();
         set_width(width);
         req_mode = gap_mode_type'($urandom_range(0, 2));
         rsp_mode = gap_mode_type'($urandom_range(0, 2));
         if (hold_phase) begin
            // back-to-back full-width requests against a stalled output
            req_mode     = GAP_NONE;
            long_hold_go = 1'b1;
         end
         streams = (width == 0) ? 1 : $urandom_range(1, 3);
         for (int s = 0; s < streams; s++) begin
            len = (hold_phase && s == 0) ? HOLD_RUN : $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
               fin = (i == len - 1) && !((s == streams - 1) && ($urandom_range(0, 3) == 0));
               send_value(pick_value(), fin);
               counted++;
            end
         end
      end

      // ---- wind-down ----
      req_if.valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending_bytes != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (pending_bytes != 0)
         $error("%0d expected bytes never arrived", pending_bytes);
      $display("Run: %0d requests over %0d width settings (0, 1..32, saturating above)",
               value_count, phase_count);
      $display("     %0d packed bytes compared, incl. a long output stall", bytes_checked);
      if (mismatch_count == 0 && pending_bytes == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
